@@ src/lcc_pkg.sv @@
`default_nettype none
package lcc_pkg;

  localparam int unsigned DigitW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned SumW    = 4;
  localparam int unsigned PrefixN = 6;
  localparam int unsigned PrefixW = PrefixN * DigitW;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned RangeW  = 11;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [TypeW-1:0] TYPE_UNKNOWN  = 3'd0;
  localparam logic [TypeW-1:0] TYPE_AMEX     = 3'd1;
  localparam logic [TypeW-1:0] TYPE_DISCOVER = 3'd2;
  localparam logic [TypeW-1:0] TYPE_MASTER   = 3'd3;
  localparam logic [TypeW-1:0] TYPE_VISA     = 3'd4;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              last_digit;
  } lcc_in_t;

  typedef struct packed {
    logic [TypeW-1:0] card_type;
    logic             card_valid;
  } lcc_out_t;

  // Item handed from the input stage to the engine.
  typedef struct packed {
    logic    advance;
    lcc_in_t item;
  } lcc_step_t;

  // Reduce a value below 40 modulo ten.
  function automatic logic [SumW-1:0] mod10(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    begin
      r = v;
      if (r >= 5'd30) begin
        r = r - 5'd30;
      end else if (r >= 5'd20) begin
        r = r - 5'd20;
      end else if (r >= 5'd10) begin
        r = r - 5'd10;
      end
      mod10 = r[SumW-1:0];
    end
  endfunction

  // Luhn doubling: 2d, minus nine when above nine.
  function automatic logic [CountW-1:0] luhn_double(input logic [DigitW-1:0] d);
    logic [CountW-1:0] t;
    begin
      t = {d, 1'b0};
      luhn_double = (t > 5'd9) ? (t - 5'd9) : t;
    end
  endfunction

  function automatic logic [DigitW-1:0] pdig(input logic [PrefixW-1:0] p, input int unsigned i);
    begin
      pdig = p[DigitW*i +: DigitW];
    end
  endfunction

  function automatic logic [TypeW-1:0] classify(input logic [PrefixW-1:0] p,
                                                input logic [CountW-1:0]  cnt);
    logic [RangeW-1:0] range;
    logic [TypeW-1:0]  t;
    begin
      range = RangeW'(pdig(p, 3)) * RangeW'(100) + RangeW'(pdig(p, 4)) * RangeW'(10)
            + RangeW'(pdig(p, 5));
      t = TYPE_UNKNOWN;
      if (cnt >= 5'd2 && pdig(p, 0) == 4'd3 && (pdig(p, 1) == 4'd4 || pdig(p, 1) == 4'd7)) begin
        t = TYPE_AMEX;
      end else if (cnt >= 5'd4 && pdig(p, 0) == 4'd6 && pdig(p, 1) == 4'd0 &&
                   pdig(p, 2) == 4'd1 && pdig(p, 3) == 4'd1) begin
        t = TYPE_DISCOVER;
      end else if (cnt >= 5'd2 && pdig(p, 0) == 4'd6 && pdig(p, 1) == 4'd5) begin
        t = TYPE_DISCOVER;
      end else if (cnt >= 5'd6 && pdig(p, 0) == 4'd6 && pdig(p, 1) == 4'd2 &&
                   pdig(p, 2) == 4'd2 && range >= 11'd126 && range < 11'd926) begin
        t = TYPE_DISCOVER;
      end else if (cnt >= 5'd2 && pdig(p, 0) == 4'd5 && pdig(p, 1) < 4'd6) begin
        t = TYPE_MASTER;
      end else if (cnt >= 5'd1 && pdig(p, 0) == 4'd4) begin
        t = TYPE_VISA;
      end
      classify = t;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/lcc_in_stage.sv @@
`default_nettype none
module lcc_in_stage
  import lcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire lcc_in_t in_data_i,
  input  wire logic    out_free_i,
  output lcc_step_t    step_o
);

  logic    valid_q, valid_d;
  lcc_in_t data_q, data_d;
  logic    advance;

  // A non-final digit never waits on the output side.
  assign advance    = valid_q && (!data_q.last_digit || out_free_i);
  assign in_stall_o = valid_q && !advance;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign step_o.advance = advance;
  assign step_o.item    = data_q;

endmodule
`default_nettype wire

@@ src/lcc_engine.sv @@
`default_nettype none
module lcc_engine
  import lcc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lcc_step_t step_i,
  output logic           res_valid_o,
  output lcc_out_t       res_o
);

  logic [CountW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [SumW-1:0]    sum_even_q, sum_even_d;
  logic [SumW-1:0]    sum_odd_q, sum_odd_d;
  logic [PrefixW-1:0] prefix_q, prefix_d, prefix_upd;
  logic [DigitW-1:0]  d;
  logic [CountW-1:0] d_plain, d_dbl;
  logic [SumW-1:0]    sel, luhn;
  logic [TypeW-1:0]   ctype;
  logic               len_ok;

  assign d       = step_i.item.digit;
  assign d_plain = {1'b0, d};
  assign d_dbl   = luhn_double(d);
  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + 5'd1;

  always_comb begin
    prefix_upd = prefix_q;
    for (int i = 0; i < PrefixN; i++) begin
      if (cnt_q == CountW'(i)) begin
        prefix_upd[DigitW*i +: DigitW] = d;
      end
    end
  end

  // Final digit: classify on the updated prefix and count.
  assign ctype  = classify(prefix_upd, cnt_inc);
  assign sel    = cnt_q[0] ? sum_even_q : sum_odd_q;
  assign luhn   = mod10({1'b0, sel} + d_plain);
  assign len_ok = (ctype == TYPE_AMEX && cnt_inc == 5'd15) ||
                  ((ctype == TYPE_DISCOVER || ctype == TYPE_MASTER || ctype == TYPE_VISA) &&
                   cnt_inc == 5'd16) ||
                  (ctype == TYPE_VISA && cnt_inc == 5'd13);

  assign res_valid_o      = step_i.advance && step_i.item.last_digit;
  assign res_o.card_type  = ctype;
  assign res_o.card_valid = (ctype != TYPE_UNKNOWN) && len_ok && (luhn == 4'd0);

  always_comb begin
    cnt_d      = cnt_q;
    sum_even_d = sum_even_q;
    sum_odd_d  = sum_odd_q;
    prefix_d   = prefix_q;
    if (step_i.advance) begin
      if (step_i.item.last_digit) begin
        cnt_d      = '0;
        sum_even_d = '0;
        sum_odd_d  = '0;
        prefix_d   = '0;
      end else begin
        cnt_d    = cnt_inc;
        prefix_d = prefix_upd;
        if (!cnt_q[0]) begin
          sum_even_d = mod10({1'b0, sum_even_q} + d_dbl);
          sum_odd_d  = mod10({1'b0, sum_odd_q} + d_plain);
        end else begin
          sum_even_d = mod10({1'b0, sum_even_q} + d_plain);
          sum_odd_d  = mod10({1'b0, sum_odd_q} + d_dbl);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      sum_even_q <= '0;
      sum_odd_q  <= '0;
      prefix_q   <= '0;
    end else begin
      cnt_q      <= cnt_d;
      sum_even_q <= sum_even_d;
      sum_odd_q  <= sum_odd_d;
      prefix_q   <= prefix_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (cnt_q == '0 && prefix_q == '0 && sum_even_q == '0 && sum_odd_q == '0))
    else $error("state not cleared after final digit");

  a_sums_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_even_q <= 4'd9 && sum_odd_q <= 4'd9)
    else $error("luhn sum out of range");

  a_prefix_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 5'd6 |-> (prefix_q >> (DigitW * cnt_q)) == '0)
    else $error("prefix holds digits beyond count");

endmodule
`default_nettype wire

@@ src/lcc_out_stage.sv @@
`default_nettype none
module lcc_out_stage
  import lcc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     res_valid_i,
  input  wire lcc_out_t res_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output lcc_out_t      out_data_o
);

  logic     valid_q, valid_d;
  lcc_out_t data_q, data_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (free_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        data_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

@@ src/card_number_luhn_classifier_core.sv @@
// Card number classifier with Luhn check.
// Input channel: one decimal digit per item, most significant first, with
// last_digit set on the check digit. Output channel: one item per card
// number, carrying card_type (0 unknown, 1 amex, 2 discover, 3 mastercard,
// 4 visa) and card_valid (known type, allowed length, Luhn sum zero).
// Both channels use valid/stall; an item moves when valid is high and
// stall is low. Non-final digits produce no output item.
// Throughput: one digit per cycle, unless a final digit waits on a stalled
// receiver; set by the single register-to-register pass that updates the
// prefix, count and the two running sums. A final digit is captured in the
// input register, then its result in the result register (out_valid_o).
// When the receiver stalls, the result register holds its item; following
// non-final digits still flow in, and a second final digit waits in the
// input register, which then stalls the sender.
// Reset clears the count, sums, prefix and both valid flags; the state
// also clears after every final digit.
`default_nettype none
module card_number_luhn_classifier_core
  import lcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire lcc_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output lcc_out_t     out_data_o
);

  lcc_step_t step;
  logic      out_free;
  logic      res_valid;
  lcc_out_t  res;

  lcc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .step_o     (step)
  );

  lcc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lcc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_valid_needs_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.card_valid |-> out_data_o.card_type != TYPE_UNKNOWN)
    else $error("valid card with unknown type");

  a_type_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.card_type <= TYPE_VISA)
    else $error("card type code out of range");

  a_stall_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register free");

endmodule
`default_nettype wire
